/* design/spq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Beat types, command and status codes, and default sizes shared by the
// queue core and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEFAULT_CAPACITY      = 16;
  localparam int DEFAULT_PAYLOAD_WIDTH = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [31:0]  rank;
    logic [31:0]         payload;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  removed_rank;
    logic [31:0]         removed_payload;
    logic signed [31:0]  front_rank;
    logic [31:0]         front_payload;
    logic signed [31:0]  tail_rank;
    logic [31:0]         tail_payload;
    logic [4:0]          occupancy;
  } spq_out_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic                clr;
    logic signed [31:0]  rank;
  } spq_cell_ctrl_t;

endpackage
`default_nettype wire

/* design/spq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry. On insert it keeps its entry, takes the new one or takes
// its left neighbor's; on remove it takes the right one's; clear empties it.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire spq_cell_ctrl_t           ctrl,
  input  wire logic [PAYLOAD_WIDTH-1:0] new_payload,
  input  wire logic                     left_keep,
  input  wire logic                     left_valid,
  input  wire logic signed [31:0]       left_rank,
  input  wire logic [PAYLOAD_WIDTH-1:0] left_payload,
  input  wire logic                     right_valid,
  input  wire logic signed [31:0]       right_rank,
  input  wire logic [PAYLOAD_WIDTH-1:0] right_payload,
  output logic                          keep,
  output logic                          valid,
  output logic signed [31:0]            rank,
  output logic [PAYLOAD_WIDTH-1:0]      payload
);

  logic                     valid_r, valid_nxt;
  logic signed [31:0]       rank_r, rank_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_r, payload_nxt;

  // Entries of greater or equal rank stay ahead of a new insert.
  assign keep = valid_r && (rank_r >= ctrl.rank);

  always_comb begin
    valid_nxt   = valid_r;
    rank_nxt    = rank_r;
    payload_nxt = payload_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.ins && !keep) begin
      if (left_keep) begin
        valid_nxt   = 1'b1;
        rank_nxt    = ctrl.rank;
        payload_nxt = new_payload;
      end else begin
        valid_nxt   = left_valid;
        rank_nxt    = left_rank;
        payload_nxt = left_payload;
      end
    end else if (ctrl.rem) begin
      valid_nxt   = right_valid;
      rank_nxt    = right_rank;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r    <= rank_nxt;
    payload_r <= payload_nxt;
  end

  assign valid   = valid_r;
  assign rank    = rank_r;
  assign payload = payload_r;

endmodule
`default_nettype wire

/* design/sorted_priority_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded queue kept sorted by signed rank in a chain of shifting cells.
// ----------------------------------------------------------------------------
// A result beat passes through the pending stage and then the output stage.
// Throughput: one command per cycle while the input is not stalled; the cell chain updates as each command is accepted.
// The input stalls only while a finished result waits on a stalled output.
// Reset clears the cell valid bits, the entry count and both result stages;
// the entry storage itself is not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY      = DEFAULT_CAPACITY,
  parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire spq_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output spq_out_t      out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                     valid_w [CAPACITY];
  logic                     keep_w  [CAPACITY];
  logic signed [31:0]       rank_w  [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] pay_w   [CAPACITY];

  spq_cell_ctrl_t           ctrl;
  logic [PAYLOAD_WIDTH-1:0] new_pay;
  logic                     accept, empty, full, move;

  logic [CNT_W-1:0] count_r, count_nxt;

  logic               pend_r, pend_nxt;
  logic [1:0]         pend_status_r, pend_status_nxt;
  logic signed [31:0] pend_rem_rank_r, pend_rem_rank_nxt;
  logic [31:0]        pend_rem_pay_r, pend_rem_pay_nxt;

  logic               out_valid_r, out_valid_nxt;
  spq_out_t           out_r, out_nxt;

  logic signed [31:0] tail_rank_c;
  logic [31:0]        tail_pay_c;

  assign move     = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && !move;
  assign accept   = in_valid && !in_stall;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign new_pay  = PAYLOAD_WIDTH'(in_data.payload);

  always_comb begin
    ctrl.ins  = accept && (in_data.cmd == CMD_INSERT) && !full;
    ctrl.rem  = accept && (in_data.cmd == CMD_REMOVE) && !empty;
    ctrl.clr  = accept && (in_data.cmd == CMD_CLEAR) && !empty;
    ctrl.rank = in_data.rank;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_keep, l_valid, r_valid;
    logic signed [31:0]       l_rank, r_rank;
    logic [PAYLOAD_WIDTH-1:0] l_pay, r_pay;

    if (i == 0) begin : g_head
      assign l_keep  = 1'b1;
      assign l_valid = 1'b0;
      assign l_rank  = '0;
      assign l_pay   = '0;
    end else begin : g_link_left
      assign l_keep  = keep_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_rank  = rank_w[i-1];
      assign l_pay   = pay_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign r_valid = 1'b0;
      assign r_rank  = '0;
      assign r_pay   = '0;
    end else begin : g_link_right
      assign r_valid = valid_w[i+1];
      assign r_rank  = rank_w[i+1];
      assign r_pay   = pay_w[i+1];
    end

    spq_cell #(
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .new_payload   (new_pay),
      .left_keep     (l_keep),
      .left_valid    (l_valid),
      .left_rank     (l_rank),
      .left_payload  (l_pay),
      .right_valid   (r_valid),
      .right_rank    (r_rank),
      .right_payload (r_pay),
      .keep          (keep_w[i]),
      .valid         (valid_w[i]),
      .rank          (rank_w[i]),
      .payload       (pay_w[i])
    );
  end

  // The tail is the last valid cell; at most one cell sees that edge.
  always_comb begin
    logic is_tail;
    tail_rank_c = '0;
    tail_pay_c  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == CAPACITY - 1) begin
        is_tail = valid_w[i];
      end else begin
        is_tail = valid_w[i] && !valid_w[i+1];
      end
      if (is_tail) begin
        tail_rank_c = tail_rank_c | rank_w[i];
        tail_pay_c  = tail_pay_c | 32'(pay_w[i]);
      end
    end
  end

  always_comb begin
    count_nxt         = count_r;
    pend_nxt          = pend_r;
    pend_status_nxt   = pend_status_r;
    pend_rem_rank_nxt = pend_rem_rank_r;
    pend_rem_pay_nxt  = pend_rem_pay_r;
    if (move) begin
      pend_nxt = 1'b0;
    end
    if (accept) begin
      pend_nxt          = 1'b1;
      pend_status_nxt   = ST_OK;
      pend_rem_rank_nxt = '0;
      pend_rem_pay_nxt  = '0;
      case (in_data.cmd)
        CMD_INSERT: begin
          if (full) begin
            pend_status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (empty) begin
            pend_status_nxt = ST_EMPTY;
          end else begin
            count_nxt         = count_r - CNT_W'(1);
            pend_rem_rank_nxt = rank_w[0];
            pend_rem_pay_nxt  = 32'(pay_w[0]);
          end
        end
        CMD_CLEAR: begin
          if (empty) begin
            pend_status_nxt = ST_EMPTY;
          end else begin
            count_nxt = '0;
          end
        end
        default: begin
          pend_status_nxt = ST_OK;
        end
      endcase
    end
  end

  // When the pending beat moves out, the cells and count already hold the
  // state that its command left behind.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (move) begin
      out_valid_nxt           = 1'b1;
      out_nxt.status          = pend_status_r;
      out_nxt.removed_rank    = pend_rem_rank_r;
      out_nxt.removed_payload = pend_rem_pay_r;
      out_nxt.front_rank      = valid_w[0] ? rank_w[0] : '0;
      out_nxt.front_payload   = valid_w[0] ? 32'(pay_w[0]) : '0;
      out_nxt.tail_rank       = tail_rank_c;
      out_nxt.tail_payload    = tail_pay_c;
      out_nxt.occupancy       = 5'(count_r);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r   <= pend_status_nxt;
    pend_rem_rank_r <= pend_rem_rank_nxt;
    pend_rem_pay_r  <= pend_rem_pay_nxt;
    out_r           <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
